// ===== rtl/task_watchdog_monitor_macros.svh =====
// ----------------------------------------------------------------------------
// task watchdog monitor assertion macros
// shared assertion forms for the monitor rtl
// ----------------------------------------------------------------------------
`ifndef TASK_WATCHDOG_MONITOR_MACROS_SVH
`define TASK_WATCHDOG_MONITOR_MACROS_SVH

// condition implies property in the same cycle
`define TWM_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("task watchdog monitor check failed");

// condition implies property in the next cycle
`define TWM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("task watchdog monitor check failed");

`endif

// ===== rtl/twm_pkg.sv =====
// ----------------------------------------------------------------------------
// task watchdog monitor package
// sizes, codes and transfer types shared by the monitor modules
// ----------------------------------------------------------------------------
package twm_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int COUNT_W = $clog2(SLOTS + 1);

    localparam logic [1:0] REQ_REGISTER = 2'd0;
    localparam logic [1:0] REQ_FEED     = 2'd1;
    localparam logic [1:0] REQ_CHECK    = 2'd2;

    localparam logic [2:0] ST_REGISTERED = 3'd0;
    localparam logic [2:0] ST_SKIPPED    = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_FED        = 3'd3;
    localparam logic [2:0] ST_IGNORED    = 3'd4;
    localparam logic [2:0] ST_HEALTHY    = 3'd5;
    localparam logic [2:0] ST_TIMEOUT    = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic [31:0] allowed_ms;
        logic        monitor_enable;
        logic [4:0]  slot_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_result;
        logic        hw_feed;
        logic [3:0]  late_slot;
        logic [31:0] late_elapsed;
    } t_out_item;

    // check walk travelling down the cell chain
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       elapsed;
        logic [31:0]       now;
    } t_walk;

    // per cell write control
    typedef struct packed {
        logic used;
        logic wr_tmo;
        logic wr_last;
    } t_cell_ctl;

    // write data shared by all cells
    typedef struct packed {
        logic [31:0] tmo;
        logic [31:0] last;
    } t_cell_data;

endpackage

// ===== rtl/task_watchdog_monitor.sv =====
// ----------------------------------------------------------------------------
// task watchdog monitor
// table of monitored tasks with register, feed and periodic check requests
// ----------------------------------------------------------------------------
// One request is taken at a time. A register or feed result passes through the
// result register and then the output register, and the request holds the
// block until its result moves to the output register. A check runs through a
// chain of SLOTS slot cells, one cell per cycle, then through the result and
// output registers, and holds the block in the same way. A stalled output
// keeps the request after the waiting one in its hold state. The output
// register lets the next request start while a result waits. A request of
// type 3 is taken and gives no result.
module task_watchdog_monitor
    import twm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

`include "task_watchdog_monitor_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    t_out_item          r_res;
    t_out_item          n_res;
    t_out_item          r_out;
    logic               r_out_valid;

    logic       w_accept;
    logic       w_reg_ok;
    logic       w_feed_ok;
    logic       w_out_free;
    t_walk      w_launch;
    t_walk      w_walk [SLOTS+1];
    t_cell_ctl  w_ctl  [SLOTS];
    t_cell_data w_data;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_reg_ok  = w_accept && (i_in.req_type == REQ_REGISTER) && i_in.monitor_enable
                       && (32'(r_count) < 32'(SLOTS));
    assign w_feed_ok = w_accept && (i_in.req_type == REQ_FEED)
                       && (32'(i_in.slot_index) < 32'(r_count))
                       && (32'(i_in.slot_index) < 32'(SLOTS));

    assign w_data.tmo  = i_in.allowed_ms;
    assign w_data.last = (i_in.req_type == REQ_FEED) ? i_in.now_ms : 32'd0;

    always_comb begin
        w_launch         = '0;
        w_launch.valid   = w_accept && (i_in.req_type == REQ_CHECK);
        w_launch.now     = i_in.now_ms;
    end

    assign w_walk[0] = w_launch;

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        always_comb begin
            w_ctl[k].used    = (32'(k) < 32'(r_count));
            w_ctl[k].wr_tmo  = w_reg_ok && (32'(r_count) == 32'(k));
            w_ctl[k].wr_last = (w_reg_ok && (32'(r_count) == 32'(k)))
                               || (w_feed_ok && (32'(i_in.slot_index) == 32'(k)));
        end

        twm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_slot_id (SLOT_W'(k)),
            .i_ctl     (w_ctl[k]),
            .i_data    (w_data),
            .i_walk    (w_walk[k]),
            .o_walk    (w_walk[k+1])
        );
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res = '0;
                    unique case (i_in.req_type)
                        REQ_REGISTER: begin
                            n_state = S_HOLD;
                            if (!i_in.monitor_enable) begin
                                n_res.status = ST_SKIPPED;
                            end else if (w_reg_ok) begin
                                n_res.status      = ST_REGISTERED;
                                n_res.slot_result = 4'(r_count);
                                n_count           = r_count + COUNT_W'(1);
                            end else begin
                                n_res.status = ST_FULL;
                            end
                        end
                        REQ_FEED: begin
                            n_state      = S_HOLD;
                            n_res.status = w_feed_ok ? ST_FED : ST_IGNORED;
                        end
                        REQ_CHECK: begin
                            n_state = S_WALK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (w_walk[SLOTS].valid) begin
                    n_state = S_HOLD;
                    n_res   = '0;
                    if (w_walk[SLOTS].hit) begin
                        n_res.status       = ST_TIMEOUT;
                        n_res.late_slot    = 4'(w_walk[SLOTS].slot);
                        n_res.late_elapsed = w_walk[SLOTS].elapsed;
                    end else begin
                        n_res.status  = ST_HEALTHY;
                        n_res.hw_feed = 1'b1;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if ((r_state == S_HOLD) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_res <= n_res;
        if ((r_state == S_HOLD) && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `TWM_ASSERT_SAME(a_walk_only_when_busy, i_clk, i_rst_n,
        w_walk[SLOTS].valid, r_state == S_WALK)
    `TWM_ASSERT_NEXT(a_register_grows_count, i_clk, i_rst_n,
        w_reg_ok, r_count == $past(r_count) + COUNT_W'(1))
    `TWM_ASSERT_NEXT(a_hold_delivers, i_clk, i_rst_n,
        (r_state == S_HOLD) && w_out_free, r_out_valid && (r_state == S_IDLE))
    `TWM_ASSERT_SAME(a_feed_means_healthy, i_clk, i_rst_n,
        r_out_valid && r_out.hw_feed, r_out.status == ST_HEALTHY)

endmodule

// ===== rtl/twm_cell.sv =====
// ----------------------------------------------------------------------------
// task watchdog monitor slot cell
// holds one slot's timeout and last report time and tests the passing walk
// ----------------------------------------------------------------------------
module twm_cell
    import twm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_slot_id,
    input  t_cell_ctl         i_ctl,
    input  t_cell_data        i_data,
    input  t_walk             i_walk,
    output t_walk             o_walk
);

    logic [31:0] r_tmo;
    logic [31:0] r_last;
    t_walk       r_walk;
    t_walk       n_walk;
    logic [31:0] w_elapsed;

    always_comb begin
        w_elapsed = i_walk.now - r_last;
        n_walk    = i_walk;
        // first late slot claims the walk, later cells pass it on untouched
        if (i_walk.valid && !i_walk.hit && i_ctl.used && (w_elapsed > r_tmo)) begin
            n_walk.hit     = 1'b1;
            n_walk.slot    = i_slot_id;
            n_walk.elapsed = w_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk.valid <= 1'b0;
        end else begin
            r_walk.valid <= n_walk.valid;
        end
        r_walk.hit     <= n_walk.hit;
        r_walk.slot    <= n_walk.slot;
        r_walk.elapsed <= n_walk.elapsed;
        r_walk.now     <= n_walk.now;
        if (i_ctl.wr_tmo) begin
            r_tmo <= i_data.tmo;
        end
        if (i_ctl.wr_last) begin
            r_last <= i_data.last;
        end
    end

    assign o_walk = r_walk;

endmodule
